// ===== design/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== design/c2s_pkg.sv =====
`default_nettype none

package c2s_pkg;

	localparam int unsigned COORD_W = 40;
	localparam int unsigned GUARD   = 8;
	localparam int unsigned DP_W    = 53;
	localparam int unsigned HI_W    = DP_W - 32;
	localparam int unsigned ANG_W   = 42;
	localparam int unsigned RND_W   = ANG_W - 10;
	localparam int unsigned LON_W   = 31;
	localparam int unsigned LAT_W   = 30;
	localparam int unsigned RAD_W   = 39;
	localparam int unsigned SERIES  = 20;

	localparam logic signed [ANG_W-1:0] DEG180   = 42'sd773094113280;
	localparam logic signed [ANG_W-1:0] DEG45    = 42'sd193273528320;
	localparam logic signed [ANG_W-1:0] ANG_HALF = 42'sd512;
	localparam logic signed [RND_W-1:0] LON_LIMIT = 32'sd754974720;
	localparam logic signed [RND_W-1:0] LAT_LIMIT = 32'sd377487360;
	localparam logic [31:0] INV_GAIN = 32'h9B74EDA8;
	localparam logic [RAD_W-1:0] RADIUS_RESET = 39'd6378137000;
	localparam logic [DP_W-1:0] MAG_HALF = DP_W'(1) << (GUARD - 1);

	// 180/pi scaled by 2^56, and its quotients by the odd series divisors.
	localparam logic [63:0] RAD2DEG_Q56 = 64'd4128596020240314225;
	localparam logic [63:0] ATAN_QUOT [SERIES] = '{
		RAD2DEG_Q56 / 64'd1,  RAD2DEG_Q56 / 64'd3,  RAD2DEG_Q56 / 64'd5,
		RAD2DEG_Q56 / 64'd7,  RAD2DEG_Q56 / 64'd9,  RAD2DEG_Q56 / 64'd11,
		RAD2DEG_Q56 / 64'd13, RAD2DEG_Q56 / 64'd15, RAD2DEG_Q56 / 64'd17,
		RAD2DEG_Q56 / 64'd19, RAD2DEG_Q56 / 64'd21, RAD2DEG_Q56 / 64'd23,
		RAD2DEG_Q56 / 64'd25, RAD2DEG_Q56 / 64'd27, RAD2DEG_Q56 / 64'd29,
		RAD2DEG_Q56 / 64'd31, RAD2DEG_Q56 / 64'd33, RAD2DEG_Q56 / 64'd35,
		RAD2DEG_Q56 / 64'd37, RAD2DEG_Q56 / 64'd39
	};

	// Arctangent of 2^-i in units of 2^-32 degree, from a truncated Taylor series.
	function automatic logic signed [ANG_W-1:0] atan_step(input int unsigned i);
		logic [63:0] acc;
		int unsigned sh;
		int unsigned k;
		acc = '0;
		if (i == 0) begin
			acc = 64'(DEG45);
		end else begin
			for (k = 0; k < SERIES; k++) begin
				sh = 24 + i * (2 * k + 1);
				if (sh < 64) begin
					if (k[0])
						acc = acc - (ATAN_QUOT[k] >> sh);
					else
						acc = acc + (ATAN_QUOT[k] >> sh);
				end
			end
		end
		return $signed(acc[ANG_W-1:0]);
	endfunction

	// Round from 2^-32 to 2^-22 degree with a floor shift, then clamp.
	function automatic logic signed [RND_W-1:0] round_angle(
		input logic signed [ANG_W-1:0] a,
		input logic signed [RND_W-1:0] lim
	);
		logic signed [ANG_W-1:0] sum;
		logic signed [RND_W-1:0] q;
		sum = a + ANG_HALF;
		q = $signed(sum[ANG_W-1:10]);
		if (q > lim)
			q = lim;
		else if (q < -lim)
			q = -lim;
		return q;
	endfunction

endpackage

`default_nettype wire

// ===== design/c2s_vec_stage.sv =====
`default_nettype none

module c2s_vec_stage #(
	parameter int unsigned IDX  = 0,
	parameter int unsigned SB_W = 1
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               up_valid,
	output logic                                    up_ready,
	input  wire logic signed [c2s_pkg::DP_W-1:0]    x_in,
	input  wire logic signed [c2s_pkg::DP_W-1:0]    y_in,
	input  wire logic signed [c2s_pkg::ANG_W-1:0]   a_in,
	input  wire logic [SB_W-1:0]                    sb_in,
	output logic                                    dn_valid,
	input  wire logic                               dn_ready,
	output logic signed [c2s_pkg::DP_W-1:0]         x_out,
	output logic signed [c2s_pkg::DP_W-1:0]         y_out,
	output logic signed [c2s_pkg::ANG_W-1:0]        a_out,
	output logic [SB_W-1:0]                         sb_out
);

	localparam logic signed [c2s_pkg::ANG_W-1:0] ANG_STEP = c2s_pkg::atan_step(IDX);

	logic                                vld_s1;
	logic signed [c2s_pkg::DP_W-1:0]     x_s1;
	logic signed [c2s_pkg::DP_W-1:0]     y_s1;
	logic signed [c2s_pkg::ANG_W-1:0]    a_s1;
	logic [SB_W-1:0]                     sb_s1;
	logic signed [c2s_pkg::DP_W-1:0]     dx;
	logic signed [c2s_pkg::DP_W-1:0]     dy;
	logic signed [c2s_pkg::DP_W-1:0]     x_nxt;
	logic signed [c2s_pkg::DP_W-1:0]     y_nxt;
	logic signed [c2s_pkg::ANG_W-1:0]    a_nxt;

	assign up_ready = !vld_s1 || dn_ready;

	// Rotate toward the positive x axis: the sign of y picks the direction.
	always_comb begin
		dx = y_in >>> IDX;
		dy = x_in >>> IDX;
		if (!y_in[c2s_pkg::DP_W-1]) begin
			x_nxt = x_in + dx;
			y_nxt = y_in - dy;
			a_nxt = a_in + ANG_STEP;
		end else begin
			x_nxt = x_in - dx;
			y_nxt = y_in + dy;
			a_nxt = a_in - ANG_STEP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (up_ready) begin
			vld_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			x_s1  <= x_nxt;
			y_s1  <= y_nxt;
			a_s1  <= a_nxt;
			sb_s1 <= sb_in;
		end
	end

	assign dn_valid = vld_s1;
	assign x_out    = x_s1;
	assign y_out    = y_s1;
	assign a_out    = a_s1;
	assign sb_out   = sb_s1;

endmodule

`default_nettype wire

// ===== design/c2s_vec_unit.sv =====
`default_nettype none

module c2s_vec_unit #(
	parameter int unsigned STEPS = 32,
	parameter int unsigned SB_W  = 1
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               up_valid,
	output logic                                    up_ready,
	input  wire logic signed [c2s_pkg::DP_W-1:0]    x_in,
	input  wire logic signed [c2s_pkg::DP_W-1:0]    y_in,
	input  wire logic signed [c2s_pkg::ANG_W-1:0]   a_in,
	input  wire logic [SB_W-1:0]                    sb_in,
	output logic                                    dn_valid,
	input  wire logic                               dn_ready,
	output logic signed [c2s_pkg::DP_W-1:0]         x_out,
	output logic signed [c2s_pkg::ANG_W-1:0]        a_out,
	output logic [SB_W-1:0]                         sb_out
);

	logic                                vld_c [STEPS+1];
	logic                                rdy_c [STEPS+1];
	logic signed [c2s_pkg::DP_W-1:0]     x_c   [STEPS+1];
	logic signed [c2s_pkg::DP_W-1:0]     y_c   [STEPS+1];
	logic signed [c2s_pkg::ANG_W-1:0]    a_c   [STEPS+1];
	logic [SB_W-1:0]                     sb_c  [STEPS+1];

	assign vld_c[0]     = up_valid;
	assign up_ready     = rdy_c[0];
	assign x_c[0]       = x_in;
	assign y_c[0]       = y_in;
	assign a_c[0]       = a_in;
	assign sb_c[0]      = sb_in;
	assign rdy_c[STEPS] = dn_ready;

	for (genvar g = 0; g < STEPS; g++) begin : g_step
		c2s_vec_stage #(
			.IDX  (g),
			.SB_W (SB_W)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (vld_c[g]),
			.up_ready (rdy_c[g]),
			.x_in     (x_c[g]),
			.y_in     (y_c[g]),
			.a_in     (a_c[g]),
			.sb_in    (sb_c[g]),
			.dn_valid (vld_c[g+1]),
			.dn_ready (rdy_c[g+1]),
			.x_out    (x_c[g+1]),
			.y_out    (y_c[g+1]),
			.a_out    (a_c[g+1]),
			.sb_out   (sb_c[g+1])
		);
	end

	// The final y residue is not needed downstream.
	assign dn_valid = vld_c[STEPS];
	assign x_out    = x_c[STEPS];
	assign a_out    = a_c[STEPS];
	assign sb_out   = sb_c[STEPS];

endmodule

`default_nettype wire

// ===== design/c2s_gain.sv =====
`default_nettype none
`include "assert_macros.svh"

module c2s_gain #(
	parameter int unsigned SB_W = 1
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          up_valid,
	output logic                               up_ready,
	input  wire logic [c2s_pkg::DP_W-1:0]      mag,
	input  wire logic [SB_W-1:0]               sb_in,
	output logic                               dn_valid,
	input  wire logic                          dn_ready,
	output logic [c2s_pkg::DP_W-1:0]           res,
	output logic [SB_W-1:0]                    sb_out
);

	logic                              vld_s1;
	logic [63:0]                       p_lo_s1;
	logic [c2s_pkg::HI_W-1:0]          hi_s1;
	logic [SB_W-1:0]                   sb_s1;
	logic                              vld_s2;
	logic [c2s_pkg::DP_W-1:0]          res_s2;
	logic [SB_W-1:0]                   sb_s2;
	logic                              rdy_s1;
	logic                              rdy_s2;
	logic [63:0]                       p_lo;
	logic [c2s_pkg::HI_W+31:0]         p_hi;

	assign rdy_s2   = !vld_s2 || dn_ready;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign up_ready = rdy_s1;

	// The low word is multiplied first; the high word and the sum follow a stage later.
	assign p_lo = {32'd0, mag[31:0]} * {32'd0, c2s_pkg::INV_GAIN};
	assign p_hi = {32'd0, hi_s1} * {{c2s_pkg::HI_W{1'b0}}, c2s_pkg::INV_GAIN};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (rdy_s1)
				vld_s1 <= up_valid;
			if (rdy_s2)
				vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && up_valid) begin
			p_lo_s1 <= p_lo;
			hi_s1   <= mag[c2s_pkg::DP_W-1:32];
			sb_s1   <= sb_in;
		end
		if (rdy_s2 && vld_s1) begin
			res_s2 <= c2s_pkg::DP_W'(p_hi) + c2s_pkg::DP_W'(p_lo_s1[63:32]);
			sb_s2  <= sb_s1;
		end
	end

	assign dn_valid = vld_s2;
	assign res      = res_s2;
	assign sb_out   = sb_s2;

	`ASSERT_IMPLIES(a_mag_nonneg, clk, arst_n, up_valid, !mag[c2s_pkg::DP_W-1], "negative magnitude entered gain removal")

endmodule

`default_nettype wire

// ===== design/cartesian_to_spherical.sv =====
// Channel   Handshake                     Payload
// point     point_valid / point_stall     ecef_x, ecef_y, ecef_z
// result    result_valid / result_stall   longitude, latitude, height_mm
// config    cfg_valid / cfg_ready         sphere_radius_mm
//
// One point is taken per clock while point_stall is low.
// The path is the two chains of CORDIC stages, one register per rotation,
// plus two stages for each gain multiplier and three stages of setup and rounding.
// Reset clears every valid bit and loads the radius register with its default.
// A stage loads when it is empty or its successor moves, so bubbles close up
// under a stall; point_stall follows result_stall through that ready chain.
`default_nettype none
`include "assert_macros.svh"

module cartesian_to_spherical #(
	parameter int unsigned ROTATION_STEPS = 32
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                point_valid,
	output logic                                     point_stall,
	input  wire logic signed [c2s_pkg::COORD_W-1:0]  ecef_x,
	input  wire logic signed [c2s_pkg::COORD_W-1:0]  ecef_y,
	input  wire logic signed [c2s_pkg::COORD_W-1:0]  ecef_z,
	output logic                                     result_valid,
	input  wire logic                                result_stall,
	output logic signed [c2s_pkg::LON_W-1:0]         longitude,
	output logic signed [c2s_pkg::LAT_W-1:0]         latitude,
	output logic signed [c2s_pkg::COORD_W-1:0]       height_mm,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [c2s_pkg::RAD_W-1:0]           sphere_radius_mm
);

	localparam int unsigned DP_W  = c2s_pkg::DP_W;
	localparam int unsigned ANG_W = c2s_pkg::ANG_W;
	localparam int unsigned LON_W = c2s_pkg::LON_W;
	localparam int unsigned LAT_W = c2s_pkg::LAT_W;
	localparam int unsigned CW    = c2s_pkg::COORD_W;
	localparam int unsigned RMM_W = DP_W - c2s_pkg::GUARD;
	localparam int unsigned HW    = RMM_W + 1;
	localparam int unsigned EXT_W = DP_W - CW - c2s_pkg::GUARD;
	localparam int unsigned SB1_W = DP_W + 1;
	localparam int unsigned SB2_W = DP_W + LON_W;
	localparam int unsigned SB3_W = LON_W + 1;
	localparam int unsigned SB4_W = LON_W + LAT_W;

	localparam logic signed [HW-1:0] H_MAX = {{(HW - CW + 1){1'b0}}, {(CW - 1){1'b1}}};
	localparam logic signed [HW-1:0] H_MIN = ~H_MAX;
	localparam logic signed [LON_W-1:0] LON_MAX = c2s_pkg::LON_LIMIT[LON_W-1:0];
	localparam logic signed [LAT_W-1:0] LAT_MAX = c2s_pkg::LAT_LIMIT[LAT_W-1:0];

	logic [c2s_pkg::RAD_W-1:0] radius_q;

	// Input stage.
	logic                      vld_s1;
	logic                      rdy_s1;
	logic signed [DP_W-1:0]    x_s1;
	logic signed [DP_W-1:0]    y_s1;
	logic signed [DP_W-1:0]    z_s1;
	logic signed [ANG_W-1:0]   base_s1;
	logic                      xy_zero_s1;
	logic signed [DP_W-1:0]    xs;
	logic signed [DP_W-1:0]    ys;
	logic signed [DP_W-1:0]    zs;
	logic signed [ANG_W-1:0]   base;

	// Longitude unit and its gain removal.
	logic                      u1_vld;
	logic                      u1_rdy;
	logic signed [DP_W-1:0]    u1_x;
	logic signed [ANG_W-1:0]   u1_a;
	logic [SB1_W-1:0]          u1_sb;
	logic signed [DP_W-1:0]    u1_z;
	logic                      u1_xy_zero;
	logic signed [c2s_pkg::RND_W-1:0] lon_rnd;
	logic signed [LON_W-1:0]   lon_w;
	logic                      g1_vld;
	logic                      g1_rdy;
	logic [DP_W-1:0]           g1_res;
	logic [SB2_W-1:0]          g1_sb;
	logic signed [DP_W-1:0]    g1_z;
	logic signed [LON_W-1:0]   g1_lon;
	logic                      lat_zero;

	// Latitude unit and its gain removal.
	logic                      u2_vld;
	logic                      u2_rdy;
	logic signed [DP_W-1:0]    u2_x;
	logic signed [ANG_W-1:0]   u2_a;
	logic [SB3_W-1:0]          u2_sb;
	logic signed [c2s_pkg::RND_W-1:0] lat_rnd;
	logic signed [LAT_W-1:0]   lat_w;
	logic                      g2_vld;
	logic                      g2_rdy;
	logic [DP_W-1:0]           g2_res;
	logic [SB4_W-1:0]          g2_sb;

	// Radius rounding and height stages.
	logic                      vld_s2;
	logic                      rdy_s2;
	logic [RMM_W-1:0]          rmm_s2;
	logic signed [LON_W-1:0]   lon_s2;
	logic signed [LAT_W-1:0]   lat_s2;
	logic [DP_W-1:0]           r_sum;
	logic                      vld_s3;
	logic                      rdy_s3;
	logic signed [LON_W-1:0]   lon_s3;
	logic signed [LAT_W-1:0]   lat_s3;
	logic signed [CW-1:0]      h_s3;
	logic signed [HW-1:0]      h_diff;
	logic signed [HW-1:0]      h_sat;

	// Configuration.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= c2s_pkg::RADIUS_RESET;
		end else if (cfg_valid) begin
			radius_q <= sphere_radius_mm;
		end
	end

	// Scale by the guard bits. A point in the left half plane is turned by 180
	// degrees so that the rotation starts from a non-negative x.
	always_comb begin
		xs = {{EXT_W{ecef_x[CW-1]}}, ecef_x, {c2s_pkg::GUARD{1'b0}}};
		ys = {{EXT_W{ecef_y[CW-1]}}, ecef_y, {c2s_pkg::GUARD{1'b0}}};
		zs = {{EXT_W{ecef_z[CW-1]}}, ecef_z, {c2s_pkg::GUARD{1'b0}}};
		if (xs[DP_W-1])
			base = ys[DP_W-1] ? -c2s_pkg::DEG180 : c2s_pkg::DEG180;
		else
			base = '0;
	end

	assign rdy_s1      = !vld_s1 || u1_rdy;
	assign point_stall = !rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rdy_s1) begin
			vld_s1 <= point_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && point_valid) begin
			x_s1       <= xs[DP_W-1] ? -xs : xs;
			y_s1       <= xs[DP_W-1] ? -ys : ys;
			z_s1       <= zs;
			base_s1    <= base;
			xy_zero_s1 <= (ecef_x == '0) && (ecef_y == '0);
		end
	end

	c2s_vec_unit #(
		.STEPS (ROTATION_STEPS),
		.SB_W  (SB1_W)
	) u_lon_unit (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (vld_s1),
		.up_ready (u1_rdy),
		.x_in     (x_s1),
		.y_in     (y_s1),
		.a_in     (base_s1),
		.sb_in    ({z_s1, xy_zero_s1}),
		.dn_valid (u1_vld),
		.dn_ready (g1_rdy),
		.x_out    (u1_x),
		.a_out    (u1_a),
		.sb_out   (u1_sb)
	);

	assign u1_z       = $signed(u1_sb[SB1_W-1:1]);
	assign u1_xy_zero = u1_sb[0];
	assign lon_rnd    = c2s_pkg::round_angle(u1_a, c2s_pkg::LON_LIMIT);
	assign lon_w      = u1_xy_zero ? '0 : lon_rnd[LON_W-1:0];

	c2s_gain #(
		.SB_W (SB2_W)
	) u_hxy_gain (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (u1_vld),
		.up_ready (g1_rdy),
		.mag      (u1_x),
		.sb_in    ({u1_z, lon_w}),
		.dn_valid (g1_vld),
		.dn_ready (u2_rdy),
		.res      (g1_res),
		.sb_out   (g1_sb)
	);

	assign g1_z     = $signed(g1_sb[SB2_W-1:LON_W]);
	assign g1_lon   = $signed(g1_sb[LON_W-1:0]);
	assign lat_zero = (g1_res == '0) && (g1_z == '0);

	c2s_vec_unit #(
		.STEPS (ROTATION_STEPS),
		.SB_W  (SB3_W)
	) u_lat_unit (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (g1_vld),
		.up_ready (u2_rdy),
		.x_in     ($signed(g1_res)),
		.y_in     (g1_z),
		.a_in     ('0),
		.sb_in    ({g1_lon, lat_zero}),
		.dn_valid (u2_vld),
		.dn_ready (g2_rdy),
		.x_out    (u2_x),
		.a_out    (u2_a),
		.sb_out   (u2_sb)
	);

	assign lat_rnd = c2s_pkg::round_angle(u2_a, c2s_pkg::LAT_LIMIT);
	assign lat_w   = u2_sb[0] ? '0 : lat_rnd[LAT_W-1:0];

	c2s_gain #(
		.SB_W (SB4_W)
	) u_r_gain (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (u2_vld),
		.up_ready (g2_rdy),
		.mag      (u2_x),
		.sb_in    ({u2_sb[SB3_W-1:1], lat_w}),
		.dn_valid (g2_vld),
		.dn_ready (rdy_s2),
		.res      (g2_res),
		.sb_out   (g2_sb)
	);

	// Round the distance to whole millimetres.
	assign r_sum  = g2_res + c2s_pkg::MAG_HALF;
	assign rdy_s3 = !vld_s3 || !result_stall;
	assign rdy_s2 = !vld_s2 || rdy_s3;

	// Height saturates to the field range.
	always_comb begin
		h_diff = $signed({1'b0, rmm_s2}) - $signed({{(HW - c2s_pkg::RAD_W){1'b0}}, radius_q});
		if (h_diff > H_MAX)
			h_sat = H_MAX;
		else if (h_diff < H_MIN)
			h_sat = H_MIN;
		else
			h_sat = h_diff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (rdy_s2)
				vld_s2 <= g2_vld;
			if (rdy_s3)
				vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && g2_vld) begin
			rmm_s2 <= r_sum[DP_W-1:c2s_pkg::GUARD];
			lon_s2 <= $signed(g2_sb[SB4_W-1:LAT_W]);
			lat_s2 <= $signed(g2_sb[LAT_W-1:0]);
		end
		if (rdy_s3 && vld_s2) begin
			lon_s3 <= lon_s2;
			lat_s3 <= lat_s2;
			h_s3   <= h_sat[CW-1:0];
		end
	end

	assign result_valid = vld_s3;
	assign longitude    = lon_s3;
	assign latitude     = lat_s3;
	assign height_mm    = h_s3;

	`ASSERT_NEXT(a_point_enters, clk, arst_n, point_valid && !point_stall, vld_s1, "accepted point did not enter the input stage")
	`ASSERT_IMPLIES(a_lon_range, clk, arst_n, result_valid, (longitude <= LON_MAX) && (longitude >= -LON_MAX), "longitude beyond its range")
	`ASSERT_IMPLIES(a_lat_range, clk, arst_n, result_valid, (latitude <= LAT_MAX) && (latitude >= -LAT_MAX), "latitude beyond its range")
	`ASSERT_NEXT(a_out_loads, clk, arst_n, vld_s2 && rdy_s3, vld_s3, "finished item did not reach the output register")

endmodule

`default_nettype wire

// ===== tb/sv/tb_cartesian_to_spherical.sv =====
module tb_cartesian_to_spherical;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned ROTATION_STEPS = 32;
	localparam int unsigned PIPE_LATENCY   = 2 * ROTATION_STEPS + 7;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned RANDOM_POINTS  = 600;

	localparam longint DEG180_Q32    = 64'sd773094113280;
	localparam longint DEG45_Q32     = 64'sd193273528320;
	localparam longint LON_CLAMP     = 64'sd754974720;
	localparam longint LAT_CLAMP     = 64'sd377487360;
	localparam longint HEIGHT_TOP    = 64'sd549755813887;
	localparam longint HEIGHT_BOTTOM = -64'sd549755813888;
	localparam longint unsigned DEG_PER_RAD_Q56 = 64'd4128596020240314225;
	localparam longint unsigned GAIN_INVERSE    = 64'h9B74EDA8;

	typedef logic signed [c2s_pkg::COORD_W-1:0] coord_t;
	typedef logic [c2s_pkg::RAD_W-1:0] radius_t;

	localparam coord_t COORD_MAX = {1'b0, {(c2s_pkg::COORD_W-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(c2s_pkg::COORD_W-1){1'b0}}};
	localparam radius_t RADIUS_MAX     = '1;
	localparam radius_t RADIUS_DEFAULT = 39'd6378137000;

	typedef struct {
		logic signed [c2s_pkg::LON_W-1:0]   lon;
		logic signed [c2s_pkg::LAT_W-1:0]   lat;
		logic signed [c2s_pkg::COORD_W-1:0] height;
	} spherical_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    point_valid = 1'b0;
	logic    point_stall;
	coord_t  ecef_x = '0;
	coord_t  ecef_y = '0;
	coord_t  ecef_z = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	logic signed [c2s_pkg::LON_W-1:0]   longitude;
	logic signed [c2s_pkg::LAT_W-1:0]   latitude;
	logic signed [c2s_pkg::COORD_W-1:0] height_mm;
	logic    cfg_valid = 1'b0;
	logic    cfg_ready;
	radius_t sphere_radius_mm = '0;

	radius_t    radius_mm = RADIUS_DEFAULT;
	spherical_t expected_spherical[$];
	int         mismatches = 0;
	int         results_checked = 0;
	int         points_sent = 0;
	int         radius_writes = 0;
	int         stall_left = 0;
	int         quiet_cycles = 0;
	bit         no_idle = 1'b0;

	cartesian_to_spherical #(
		.ROTATION_STEPS(ROTATION_STEPS)
	) u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.point_valid     (point_valid),
		.point_stall     (point_stall),
		.ecef_x          (ecef_x),
		.ecef_y          (ecef_y),
		.ecef_z          (ecef_z),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.longitude       (longitude),
		.latitude        (latitude),
		.height_mm       (height_mm),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.sphere_radius_mm(sphere_radius_mm)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Arctangent of 2^-i in 2^-32 degree, from the truncated odd Taylor terms.
	function automatic longint atan_q32(int unsigned i);
		longint unsigned acc;
		longint unsigned term;
		int unsigned k;
		if (i == 0)
			return DEG45_Q32;
		acc = 0;
		for (k = 0; 24 + i * (2 * k + 1) < 64; k++) begin
			term = (DEG_PER_RAD_Q56 / longint'(2 * k + 1)) >> (24 + i * (2 * k + 1));
			if (k[0])
				acc = acc - term;
			else
				acc = acc + term;
		end
		return longint'(acc);
	endfunction

	// Rotates (mag, yv) onto the positive axis; mag keeps the scaled length.
	function automatic longint cordic_vector(inout longint mag, input longint yv);
		longint ang;
		longint dx;
		longint dy;
		int unsigned i;
		ang = 0;
		for (i = 0; i < ROTATION_STEPS && i < 62; i++) begin
			dx = yv >>> i;
			dy = mag >>> i;
			if (yv >= 0) begin
				mag = mag + dx;
				yv = yv - dy;
				ang = ang + atan_q32(i);
			end else begin
				mag = mag - dx;
				yv = yv + dy;
				ang = ang - atan_q32(i);
			end
		end
		return ang;
	endfunction

	function automatic longint strip_gain(longint a);
		longint unsigned m;
		longint unsigned hi;
		longint unsigned lo;
		m = a;
		hi = m >> 32;
		lo = m & 64'hFFFF_FFFF;
		return longint'(hi * GAIN_INVERSE + ((lo * GAIN_INVERSE) >> 32));
	endfunction

	function automatic longint round_deg(longint a, longint lim);
		longint r;
		r = (a + 512) >>> 10;
		if (r > lim)
			r = lim;
		if (r < -lim)
			r = -lim;
		return r;
	endfunction

	function automatic spherical_t predict_spherical(coord_t px, coord_t py, coord_t pz);
		longint x;
		longint y;
		longint z;
		longint lon;
		longint lat;
		longint hxy;
		longint base;
		longint m;
		longint r;
		longint h;
		spherical_t res;
		x = longint'(px) * 256;
		y = longint'(py) * 256;
		z = longint'(pz) * 256;
		lon = 0;
		lat = 0;
		hxy = 0;
		if (x != 0 || y != 0) begin
			base = 0;
			// The left half plane is folded over before the rotations start.
			if (x < 0) begin
				base = (y >= 0) ? DEG180_Q32 : -DEG180_Q32;
				x = -x;
				y = -y;
			end
			lon = round_deg(base + cordic_vector(x, y), LON_CLAMP);
			hxy = strip_gain(x);
		end
		if (hxy != 0 || z != 0) begin
			m = hxy;
			lat = round_deg(cordic_vector(m, z), LAT_CLAMP);
			r = strip_gain(m);
		end else begin
			r = 0;
		end
		h = ((r + 128) >>> 8) - longint'(radius_mm);
		if (h > HEIGHT_TOP)
			h = HEIGHT_TOP;
		if (h < HEIGHT_BOTTOM)
			h = HEIGHT_BOTTOM;
		res.lon = lon[c2s_pkg::LON_W-1:0];
		res.lat = lat[c2s_pkg::LAT_W-1:0];
		res.height = h[c2s_pkg::COORD_W-1:0];
		return res;
	endfunction

	// Mostly sign-extended values of random width, so every magnitude shows up.
	function automatic coord_t rand_coord();
		logic [63:0] raw;
		int unsigned w;
		int unsigned pick;
		raw = {$urandom, $urandom};
		pick = $urandom_range(0, 11);
		w = $urandom_range(1, 40);
		if (pick == 0)
			return '0;
		if (pick == 1)
			return COORD_MAX;
		if (pick == 2)
			return COORD_MIN;
		return coord_t'($signed(raw) >>> (64 - w));
	endfunction

	function automatic int unsigned idle_draw();
		return no_idle ? 0 : $urandom_range(0, 4);
	endfunction

	task automatic send_point(coord_t x, coord_t y, coord_t z);
		int unsigned gap;
		gap = idle_draw();
		if (gap > 0) begin
			@(negedge clk) point_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		point_valid <= 1'b1;
		ecef_x <= x;
		ecef_y <= y;
		ecef_z <= z;
		do @(posedge clk); while (point_stall);
		expected_spherical = {expected_spherical, predict_spherical(x, y, z)};
		points_sent++;
	endtask

	task automatic release_points();
		@(negedge clk) point_valid <= 1'b0;
	endtask

	task automatic wait_for_results();
		while (expected_spherical.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_radius(radius_t value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		sphere_radius_mm <= value;
		do @(posedge clk); while (!cfg_ready);
		radius_mm = value;
		radius_writes++;
		@(negedge clk) cfg_valid <= 1'b0;
	endtask

	// Runs on the reset value of the radius, before any register write.
	task automatic test_extreme_points();
		send_point(0, 0, 0);
		send_point(COORD_MAX, 0, 0);
		send_point(COORD_MIN, 0, 0);
		send_point(0, COORD_MAX, 0);
		send_point(0, COORD_MIN, 0);
		send_point(0, 0, COORD_MAX);
		send_point(0, 0, COORD_MIN);
		send_point(COORD_MAX, COORD_MAX, COORD_MAX);
		send_point(COORD_MIN, COORD_MIN, COORD_MIN);
		send_point(COORD_MAX, COORD_MIN, 0);
		send_point(COORD_MIN, COORD_MAX, 1);
		send_point(-1, 0, 0);
		send_point(-1000, -1, 0);
		send_point(-1000, 1, 5);
		send_point(-40'sd6378137000, -40'sd1, 40'sd1);
		send_point(1, 1, 1);
		send_point(-1, -1, -1);
		send_point(40'sd6378137000, 0, 0);
		send_point(0, 0, -40'sd6378137000);
		release_points();
		wait_for_results();
	endtask

	task automatic test_radius_extremes();
		write_radius('0);
		send_point(COORD_MAX, COORD_MAX, COORD_MAX);
		send_point(COORD_MIN, COORD_MAX, COORD_MIN);
		send_point(1, 0, 0);
		send_point(0, 0, 0);
		release_points();
		wait_for_results();
		write_radius(RADIUS_MAX);
		send_point(0, 0, 0);
		send_point(COORD_MIN, COORD_MIN, COORD_MIN);
		send_point(0, -7, 0);
		release_points();
		wait_for_results();
	endtask

	task automatic test_random_points();
		int unsigned n;
		for (n = 0; n < RANDOM_POINTS; n++) begin
			if (n % 150 == 0) begin
				release_points();
				wait_for_results();
				case (n / 150)
					0: write_radius(radius_t'({$urandom, $urandom}));
					1: write_radius(RADIUS_DEFAULT);
					2: write_radius(radius_t'($urandom_range(1, 1000)));
					default: write_radius(radius_t'({$urandom, $urandom}));
				endcase
			end
			// Some stretches run back to back with no idle cycles on either side.
			if (n % 50 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			send_point(rand_coord(), rand_coord(), rand_coord());
		end
		release_points();
		no_idle = 1'b0;
		wait_for_results();
	endtask

	always @(posedge clk) begin
		spherical_t exp_res;
		if (arst_n && result_valid && !result_stall) begin
			stall_left = idle_draw();
			results_checked++;
			if (expected_spherical.size() == 0) begin
				$display("%0t: result with no request pending: lon %0d lat %0d height %0d",
					$time, longitude, latitude, height_mm);
				mismatches++;
			end else begin
				exp_res = expected_spherical.pop_front();
				if (longitude !== exp_res.lon) begin
					$display("%0t: longitude mismatch, expected %0d, actual %0d",
						$time, exp_res.lon, longitude);
					mismatches++;
				end
				if (latitude !== exp_res.lat) begin
					$display("%0t: latitude mismatch, expected %0d, actual %0d",
						$time, exp_res.lat, latitude);
					mismatches++;
				end
				if (height_mm !== exp_res.height) begin
					$display("%0t: height_mm mismatch, expected %0d, actual %0d",
						$time, exp_res.height, height_mm);
					mismatches++;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (stall_left > 0) begin
			result_stall <= 1'b1;
			stall_left = stall_left - 1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (point_valid && !point_stall) || (result_valid && !result_stall)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles = quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no request moved for %0d cycles", $time, quiet_cycles);
				$display("FAIL cartesian_to_spherical");
				$finish;
			end
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		test_extreme_points();
		test_radius_extremes();
		test_random_points();
		repeat (PIPE_LATENCY + 10) @(posedge clk);
		if (expected_spherical.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, expected_spherical.size());
			mismatches++;
		end
		$display("Sent %0d points over %0d radius settings, including the origin,",
			points_sent, radius_writes + 1);
		$display("axis extremes and saturated heights; %0d results checked, %0d mismatches.",
			results_checked, mismatches);
		if (mismatches == 0)
			$display("PASS cartesian_to_spherical");
		else
			$display("FAIL cartesian_to_spherical");
		$finish;
	end

endmodule
